[rtl/fbpa_pkg.sv]
package fbpa_pkg;

  localparam int unsigned BlockSizeW  = 16;
  localparam int unsigned PoolCountW  = 11;
  localparam int unsigned ReqSizeW    = 16;
  localparam int unsigned FreeIdxW    = 10;
  localparam int unsigned BlockIdxW   = 10;
  localparam int unsigned OffsetW     = 26;
  localparam int unsigned InUseW      = 11;
  localparam int unsigned TotalW      = 32;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [BlockSizeW-1:0] BlockSizeReset = 16'd64;
  localparam logic [PoolCountW-1:0] PoolCountReset = 11'd1024;
  localparam logic [InUseW-1:0]     InUseMax       = 11'd2047;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE = 1'b0,
    CFG_POOL_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_TOO_BIG   = 2'd1,
    STAT_EXHAUSTED = 2'd2,
    STAT_FREED     = 2'd3
  } alloc_status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage

[rtl/fbpa_ctrl.sv]
module fbpa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  output fbpa_pkg::ctrl_cmd_t cmd_o
);
  import fbpa_pkg::*;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    busy          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = start;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        busy       = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.exec;
    end
  end

  assign done_o = done_q;

  // An accepted request always yields exactly one result after ST_EXEC.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy ##1 done_o)
    else $error("accepted request did not produce a result in two cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while the block is still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_o.exec))
    else $error("result strobe without a preceding execute cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.capture && cmd_o.exec))
    else $error("capture and execute issued together");

endmodule

[rtl/fbpa_dp.sv]
module fbpa_dp #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fbpa_pkg::ctrl_cmd_t                 cmd_i,
  input  logic                                cfg_we_i,
  input  logic [fbpa_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [fbpa_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                req_type_i,
  input  logic [fbpa_pkg::ReqSizeW-1:0]       request_size_i,
  input  logic [fbpa_pkg::FreeIdxW-1:0]       free_index_i,
  output logic [1:0]                          status_o,
  output logic [fbpa_pkg::BlockIdxW-1:0]      block_index_o,
  output logic [fbpa_pkg::OffsetW-1:0]        block_offset_o,
  output logic [fbpa_pkg::InUseW-1:0]         in_use_count_o,
  output logic [fbpa_pkg::TotalW-1:0]         alloc_total_o,
  output logic [fbpa_pkg::TotalW-1:0]         free_total_o
);
  import fbpa_pkg::*;

  localparam int unsigned IdxW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned HeadW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CmpW  = (HeadW > PoolCountW) ? HeadW : PoolCountW;
  localparam logic [CmpW-1:0]  MaxCmp   = CmpW'(MAX_BLOCKS);
  localparam logic [HeadW-1:0] EmptyMark = HeadW'(MAX_BLOCKS);

  logic [BlockSizeW-1:0] block_size_q;
  logic [PoolCountW-1:0] pool_count_q;

  logic [HeadW-1:0]  head_q, head_d;
  logic [HeadW-1:0]  carved_q, carved_d;
  logic [InUseW-1:0] in_use_q, in_use_d;
  logic [TotalW-1:0] alloc_cnt_q, alloc_cnt_d;
  logic [TotalW-1:0] free_cnt_q, free_cnt_d;

  logic                req_q;
  logic [ReqSizeW-1:0] size_q;
  logic [FreeIdxW-1:0] fidx_q;

  logic [HeadW-1:0] mem [MAX_BLOCKS];
  logic [HeadW-1:0] rd_q;

  logic [1:0]              status_q;
  logic [BlockIdxW-1:0]    index_q;
  logic [OffsetW-1:0]      offset_q;

  logic             head_valid;
  logic [CmpW-1:0]  limit;
  logic [CmpW-1:0]  fidx_ext;
  logic             fidx_ok;
  logic             too_big;
  logic             can_carve;
  logic             alloc_ok;
  logic             free_ok;
  logic [HeadW-1:0] alloc_idx;
  logic [CmpW-1:0]  alloc_idx_ext;
  logic [31:0]      product;
  alloc_status_e    status_d;

  assign head_valid = (head_q != EmptyMark);
  assign limit      = (CmpW'(pool_count_q) < MaxCmp) ? CmpW'(pool_count_q) : MaxCmp;
  assign fidx_ext   = CmpW'(fidx_q);
  assign fidx_ok    = (fidx_ext < MaxCmp);
  assign too_big    = (size_q > block_size_q);
  assign can_carve  = (CmpW'(carved_q) < limit);
  assign alloc_ok   = (req_q == REQ_ALLOC) && !too_big && (head_valid || can_carve);
  assign free_ok    = (req_q == REQ_FREE) && fidx_ok;
  assign alloc_idx  = head_valid ? head_q : carved_q;
  assign alloc_idx_ext = CmpW'(alloc_idx);
  assign product    = 32'(alloc_idx[IdxW-1:0]) * 32'(block_size_q);

  always_comb begin
    head_d      = head_q;
    carved_d    = carved_q;
    in_use_d    = in_use_q;
    alloc_cnt_d = alloc_cnt_q;
    free_cnt_d  = free_cnt_q;
    if (req_q == REQ_FREE) begin
      status_d = STAT_FREED;
    end else if (too_big) begin
      status_d = STAT_TOO_BIG;
    end else if (alloc_ok) begin
      status_d = STAT_ALLOCATED;
    end else begin
      status_d = STAT_EXHAUSTED;
    end
    if (alloc_ok) begin
      if (head_valid) begin
        head_d = rd_q;
      end else begin
        carved_d = carved_q + 1'b1;
      end
      if (in_use_q != InUseMax) begin
        in_use_d = in_use_q + 1'b1;
      end
      alloc_cnt_d = alloc_cnt_q + 1'b1;
    end
    if (free_ok) begin
      head_d = HeadW'(fidx_ext);
      if (in_use_q != '0) begin
        in_use_d = in_use_q - 1'b1;
      end
      free_cnt_d = free_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BlockSizeReset;
      pool_count_q <= PoolCountReset;
      head_q       <= EmptyMark;
      carved_q     <= '0;
      in_use_q     <= '0;
      alloc_cnt_q  <= '0;
      free_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_BLOCK_SIZE: block_size_q <= cfg_data_i[BlockSizeW-1:0];
          CFG_POOL_COUNT: pool_count_q <= cfg_data_i[PoolCountW-1:0];
          default: begin
            block_size_q <= block_size_q;
          end
        endcase
      end
      if (cmd_i.exec) begin
        head_q      <= head_d;
        carved_q    <= carved_d;
        in_use_q    <= in_use_d;
        alloc_cnt_q <= alloc_cnt_d;
        free_cnt_q  <= free_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      size_q <= request_size_i;
      fidx_q <= free_index_i;
      if (head_valid) begin
        rd_q <= mem[head_q[IdxW-1:0]];
      end
    end
    if (cmd_i.exec && free_ok) begin
      mem[fidx_ext[IdxW-1:0]] <= head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      index_q  <= alloc_ok ? alloc_idx_ext[BlockIdxW-1:0] : '0;
      offset_q <= alloc_ok ? product[OffsetW-1:0] : '0;
    end
  end

  assign status_o       = status_q;
  assign block_index_o  = index_q;
  assign block_offset_o = offset_q;
  assign in_use_count_o = in_use_q;
  assign alloc_total_o  = alloc_cnt_q;
  assign free_total_o   = free_cnt_q;

  // Carving never runs past the memory depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(carved_q) <= MaxCmp)
    else $error("carved count beyond pool depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && alloc_ok && !head_valid) |=> (carved_q == $past(carved_q) + 1'b1))
    else $error("carve did not advance the carved count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && !alloc_ok && !free_ok) |=>
      (head_q == $past(head_q) && carved_q == $past(carved_q)))
    else $error("failed request changed the free list");

endmodule

[rtl/fixed_block_pool_allocator.sv]
// Fixed-block pool allocator with a LIFO free list. A request is taken at a rising edge
// where start is high and busy is low; busy is then high for one cycle, and the result
// word appears on the result ports with done_o high in the following cycle. The block
// takes no new request while busy, as the execute step uses the registered read of the
// next-index memory at the free-list head; a new request may be accepted in the same
// cycle that the previous result is shown. Results are shown for exactly one cycle and
// cannot be held off by the receiver. Configuration writes are always ready and should
// only be issued while no request is in flight.
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fbpa_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fbpa_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              req_type_i,
  input  logic [fbpa_pkg::ReqSizeW-1:0]     request_size_i,
  input  logic [fbpa_pkg::FreeIdxW-1:0]     free_index_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [fbpa_pkg::BlockIdxW-1:0]    block_index_o,
  output logic [fbpa_pkg::OffsetW-1:0]      block_offset_o,
  output logic [fbpa_pkg::InUseW-1:0]       in_use_count_o,
  output logic [fbpa_pkg::TotalW-1:0]       alloc_total_o,
  output logic [fbpa_pkg::TotalW-1:0]       free_total_o
);
  import fbpa_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .request_size_i (request_size_i),
    .free_index_i   (free_index_i),
    .status_o       (status_o),
    .block_index_o  (block_index_o),
    .block_offset_o (block_offset_o),
    .in_use_count_o (in_use_count_o),
    .alloc_total_o  (alloc_total_o),
    .free_total_o   (free_total_o)
  );

endmodule
